// ----- rtl/mpe_pkg.sv -----
// ----------------------------------------------------------------------------
// mpe_pkg
// shared types, constants and the per-letter coding rules of the encoder
// ----------------------------------------------------------------------------
package mpe_pkg;

    localparam int unsigned DEF_MAX_CODE_LEN = 50;
    localparam logic [5:0]  CFG_RESET        = 6'd50;
    localparam int unsigned Q_DEPTH          = 4;
    localparam int unsigned Q_PTR_W          = $clog2(Q_DEPTH);
    localparam int unsigned WIN              = 7;
    localparam logic [3:0]  SEEN_SAT         = 4'd15;
    localparam logic [7:0]  CH_SP            = 8'h20;
    localparam logic [7:0]  CH_TH            = 8'h30;

    // one queue entry: up to two letters for the window, then maybe end of word
    typedef struct packed {
        logic       a_v;
        logic [7:0] a;
        logic       b_v;
        logic [7:0] b;
        logic       flush;
    } t_op;

    typedef struct packed {
        logic [1:0] n;
        logic [7:0] c0;
    } t_code;

    typedef enum logic [1:0] {PH_NONE, PH_HELD, PH_OPEN} t_phase;

    typedef enum logic [2:0] {
        BS_IDLE, BS_PUSH_A, BS_PUSH_B, BS_TRIM, BS_ALIGN, BS_FLUSH, BS_END
    } t_bstate;

    function automatic logic is_vowel(input logic [7:0] c);
        return (c == "A") || (c == "E") || (c == "I") || (c == "O") || (c == "U");
    endfunction

    function automatic logic is_front(input logic [7:0] c);
        return (c == "E") || (c == "I") || (c == "Y");
    endfunction

    function automatic logic is_varson(input logic [7:0] c);
        return (c == "C") || (c == "S") || (c == "P") || (c == "T") || (c == "G");
    endfunction

    function automatic t_code one(input logic [7:0] c);
        t_code r;
        r.n  = 2'd1;
        r.c0 = c;
        return r;
    endfunction

    // code for one letter; an X gives K now and S as second char
    function automatic t_code code_letter(input logic [1:0] pos, input logic [7:0] prev,
                                          input logic [7:0] cur, input logic [7:0] n1,
                                          input logic [7:0] n2, input logic [7:0] n3,
                                          input logic [2:0] rem);
        t_code r;
        logic  va;
        logic  fv;
        logic  vb;
        logic  sil;
        r.n  = 2'd0;
        r.c0 = CH_SP;
        va   = is_vowel(n1);
        fv   = is_front(n1);
        vb   = is_vowel(prev);
        sil  = 1'b0;
        if (pos == 2'd0 && is_vowel(cur)) begin
            r = one(cur);
        end else if (cur != n1) begin
            case (cur)
                "B": if (!(rem == 3'd0 && prev == "M")) r = one("B");
                "C": begin
                    if (pos > 2'd1 && prev == "S" && fv) r.n = 2'd0;
                    else if (pos > 2'd0 && n1 == "I" && n2 == "A") r = one("X");
                    else if (fv) r = one("S");
                    else if (pos > 2'd1 && prev == "S" && n1 == "H") r = one("K");
                    else if (n1 == "H")
                        r = one((pos == 2'd0 && !is_vowel(n2)) ? "K" : "X");
                    else r = one((prev == "C") ? "C" : "K");
                end
                "D": r = one((n1 == "G" && is_front(n2)) ? "J" : "T");
                "G": begin
                    if (rem >= 3'd2 && n1 == "H" && !is_vowel(n2)) sil = 1'b1;
                    if (rem == 3'd3 && n1 == "N" && n2 == "E" && n3 == "D") sil = 1'b1;
                    else if (rem == 3'd1 && n1 == "N") sil = 1'b1;
                    if (prev == "D" && fv) sil = 1'b1;
                    if (!sil) r = one((fv && prev != "G") ? "J" : "K");
                end
                "H": if (!is_varson(prev) && !(vb && !va)) r = one("H");
                "F", "J", "L", "M", "N", "R": r = one(cur);
                "K": if (prev != "C") r = one("K");
                "P": r = one((n1 == "H") ? "F" : "P");
                "Q": r = one("K");
                "S": begin
                    if (pos > 2'd1 && n1 == "I" && (n2 == "O" || n2 == "A")) r = one("X");
                    else r = one((n1 == "H") ? "X" : "S");
                end
                "T": begin
                    if (pos > 2'd1 && n1 == "I" && (n2 == "O" || n2 == "A")) r = one("X");
                    else if (n1 == "H")
                        r = one((pos > 2'd0 || is_vowel(n2)) ? CH_TH : "T");
                    else if (!(rem >= 3'd3 && n1 == "C" && n2 == "H")) r = one("T");
                end
                "V": r = one("F");
                "W", "Y": if (rem > 3'd0 && va) r = one(cur);
                "X": begin
                    r.n  = 2'd2;
                    r.c0 = "K";
                end
                "Z": r = one("S");
                default: r.n = 2'd0;
            endcase
        end
        return r;
    endfunction

endpackage

// ----- rtl/mpe_in_if.sv -----
// ----------------------------------------------------------------------------
// mpe_in_if
// byte channel into the encoder
// ----------------------------------------------------------------------------
interface mpe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       last_of_word;

    modport source (output valid, output char_byte, output last_of_word, input ready);
    modport sink   (input valid, input char_byte, input last_of_word, output ready);
endinterface

// ----- rtl/mpe_out_if.sv -----
// ----------------------------------------------------------------------------
// mpe_out_if
// code character channel out of the encoder
// ----------------------------------------------------------------------------
interface mpe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_char;
    logic       has_char;
    logic       last_of_code;

    modport source (output valid, output code_char, output has_char, output last_of_code,
                    input ready);
    modport sink   (input valid, input code_char, input has_char, input last_of_code,
                    output ready);
endinterface

// ----- rtl/metaphone_phonetic_encoder.sv -----
// ----------------------------------------------------------------------------
// metaphone_phonetic_encoder
// streaming original-metaphone encoder: bytes in, code characters out
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  i_in      in   valid/ready        char_byte[7:0], last_of_word
//  o_out     out  valid/ready        code_char[7:0], has_char, last_of_code
//  i_cfg_*   in   write enable only  max_code_length[5:0]
//
//  a letter byte takes an op fetch and a window push in the back sequencer;
//  a letter coded as X adds a step for the second code character
//  the final byte adds trailing-s trim, window alignment, coding of the last
//  letters and the end transaction
//  reset is synchronous, active low; the word state and queue clear at once
//  a 4-entry queue lets the front keep taking bytes while the output stalls
// ----------------------------------------------------------------------------
module metaphone_phonetic_encoder #(
    parameter int unsigned MAX_CODE_LEN = mpe_pkg::DEF_MAX_CODE_LEN
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mpe_in_if.sink     i_in,
    mpe_out_if.source  o_out,
    input  logic       i_cfg_we,
    input  logic [5:0] i_cfg_wdata
);
    import mpe_pkg::*;

    // code length limit register
    logic [5:0] r_max_len;

    // front to queue, queue to back
    logic q_push;
    t_op  q_in_op;
    logic q_ready;
    logic q_valid;
    t_op  q_out_op;
    logic q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_wdata;
        end
    end

    // front: letter filter and prefix rules, one byte per cycle while the queue has room
    mpe_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_q_push  (q_push),
        .o_q_op    (q_in_op)
    );

    // decoupling queue
    mpe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (q_in_op),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_op    (q_out_op),
        .i_pop   (q_pop)
    );

    // back: window, context coding, flush and output register
    mpe_back #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_max_len  (r_max_len),
        .i_op_valid (q_valid),
        .i_op       (q_out_op),
        .o_op_pop   (q_pop),
        .o_out      (o_out)
    );
endmodule

// ----- rtl/mpe_front.sv -----
// ----------------------------------------------------------------------------
// mpe_front
// takes bytes, keeps letters, resolves the word prefix, queues window ops
// ----------------------------------------------------------------------------
module mpe_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mpe_in_if.sink       i_in,
    input  logic         i_q_ready,
    output logic         o_q_push,
    output mpe_pkg::t_op o_q_op
);
    import mpe_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_held, n_held;
    logic       letter;
    logic [7:0] uc;
    logic [7:0] held_now;
    logic       pair_hit;
    logic       accept;
    t_op        op;

    assign i_in.ready = i_q_ready;
    assign accept     = i_in.valid && i_q_ready;

    always_comb begin
        letter = 1'b0;
        uc     = i_in.char_byte;
        if (i_in.char_byte >= "a" && i_in.char_byte <= "z") begin
            letter = 1'b1;
            uc     = i_in.char_byte - 8'd32;
        end else if (i_in.char_byte >= "A" && i_in.char_byte <= "Z") begin
            letter = 1'b1;
        end
    end

    always_comb begin
        pair_hit = (r_held == "A" && uc == "E") || (r_held == "G" && uc == "N") ||
                   (r_held == "K" && uc == "N") || (r_held == "P" && uc == "N") ||
                   (r_held == "W" && uc == "R");
        held_now = (letter && r_phase == PH_NONE) ? uc : r_held;
        op       = '0;
        op.a     = CH_SP;
        op.b     = CH_SP;
        n_phase  = r_phase;
        n_held   = r_held;
        if (letter) begin
            unique case (r_phase)
                PH_NONE: begin
                    n_held  = uc;
                    n_phase = PH_HELD;
                end
                PH_HELD: begin
                    n_phase = PH_OPEN;
                    op.a_v  = 1'b1;
                    if (pair_hit) begin
                        op.a = uc;
                    end else if (r_held == "X") begin
                        op.a   = "S";
                        op.b_v = 1'b1;
                        op.b   = uc;
                    end else if (r_held == "W" && uc == "H") begin
                        op.a = "W";
                    end else begin
                        op.a   = r_held;
                        op.b_v = 1'b1;
                        op.b   = uc;
                    end
                end
                PH_OPEN: begin
                    op.a_v = 1'b1;
                    op.a   = uc;
                end
                default: n_phase = r_phase;
            endcase
        end
        if (i_in.last_of_word) begin
            op.flush = 1'b1;
            // a lone first letter is pushed on its own at the end
            if (n_phase == PH_HELD) begin
                op.a_v = 1'b1;
                op.a   = (held_now == "X") ? "S" : held_now;
            end
            n_phase = PH_NONE;
        end
    end

    assign o_q_push = accept && (op.a_v || op.flush);
    assign o_q_op   = op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_NONE;
            r_held  <= CH_SP;
        end else if (accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end
endmodule

// ----- rtl/mpe_queue.sv -----
// ----------------------------------------------------------------------------
// mpe_queue
// short fifo of window ops between front and back
// ----------------------------------------------------------------------------
module mpe_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  mpe_pkg::t_op i_op,
    output logic         o_ready,
    output logic         o_valid,
    output mpe_pkg::t_op o_op,
    input  logic         i_pop
);
    import mpe_pkg::*;

    t_op                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp, r_rp;
    logic [Q_PTR_W:0]   r_cnt;
    logic               do_pop;

    assign o_ready = r_cnt != (Q_PTR_W+1)'(Q_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_op    = r_mem[r_rp];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (do_pop) r_rp <= r_rp + 1'b1;
            if (i_push && !do_pop) r_cnt <= r_cnt + 1'b1;
            else if (!i_push && do_pop) r_cnt <= r_cnt - 1'b1;
        end
    end
endmodule

// ----- rtl/mpe_back.sv -----
// ----------------------------------------------------------------------------
// mpe_back
// letter window, coding sequencer, end-of-word flush and output register
// ----------------------------------------------------------------------------
module mpe_back #(
    parameter int unsigned MAX_CODE_LEN = mpe_pkg::DEF_MAX_CODE_LEN
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [5:0]   i_max_len,
    input  logic         i_op_valid,
    input  mpe_pkg::t_op i_op,
    output logic         o_op_pop,
    mpe_out_if.source    o_out
);
    import mpe_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_CODE_LEN + 2);
    localparam int unsigned LIM_W = (CNT_W > 6) ? CNT_W : 6;

    t_bstate          r_state, n_state;
    t_op              r_op, n_op;
    logic [7:0]       r_win [WIN];
    logic [7:0]       n_win [WIN];
    logic [3:0]       r_seen, n_seen;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [2:0]       r_k, n_k;
    logic [2:0]       r_sh, n_sh;
    logic             r_xs, n_xs;
    logic             r_hold_v, n_hold_v;
    logic [7:0]       r_hold_c, n_hold_c;
    logic             r_ov;
    logic [7:0]       r_oc;
    logic             r_oh, r_ol;

    logic [7:0]       push_l;
    logic [3:0]       seen_p;
    logic [3:0]       dpos;
    logic [1:0]       pos;
    logic [2:0]       rem;
    logic             code_en, active, want, emit_ok, out_free, go;
    logic             out_load, o_has, o_last;
    logic [7:0]       o_chr, chr;
    logic [LIM_W-1:0] lim;
    logic [2:0]       pend;
    t_code            res;

    assign out_free = !r_ov || o_out.ready;
    assign go       = !r_xs;
    assign o_op_pop = (r_state == BS_IDLE) && go;

    // coding datapath: both pushes and flush steps read the same window taps
    always_comb begin
        push_l  = (r_state == BS_PUSH_B) ? r_op.b : r_op.a;
        seen_p  = (r_seen == SEEN_SAT) ? r_seen : r_seen + 4'd1;
        pend    = (r_seen > 4'd5) ? 3'd5 : r_seen[2:0];
        lim     = (LIM_W'(i_max_len) > LIM_W'(MAX_CODE_LEN))
                  ? LIM_W'(MAX_CODE_LEN) : LIM_W'(i_max_len);
        if (r_state == BS_FLUSH) begin
            rem     = r_k - 3'd1;
            dpos    = r_seen - {1'b0, r_k};
            code_en = r_k != 3'd0;
        end else begin
            rem     = 3'd4;
            dpos    = seen_p - 4'd6;
            code_en = (r_state == BS_PUSH_A || r_state == BS_PUSH_B) && seen_p >= 4'd6;
        end
        pos    = (dpos > 4'd2) ? 2'd2 : dpos[1:0];
        res    = code_letter(pos, r_win[1], r_win[2], r_win[3], r_win[4], r_win[5], rem);
        active = code_en && (LIM_W'(r_cnt) < lim);
        if (r_xs) begin
            want = 1'b1;
            chr  = "S";
        end else begin
            want = active && res.n != 2'd0;
            chr  = res.c0;
        end
        emit_ok = !want || (r_op.flush ? (!r_hold_v || out_free) : out_free);
    end

    // next state
    always_comb begin
        n_state = r_state;
        if (go) begin
            unique case (r_state)
                BS_IDLE:
                    if (i_op_valid)
                        n_state = i_op.a_v ? BS_PUSH_A : (i_op.b_v ? BS_PUSH_B : BS_TRIM);
                BS_PUSH_A:
                    if (emit_ok)
                        n_state = r_op.b_v ? BS_PUSH_B : (r_op.flush ? BS_TRIM : BS_IDLE);
                BS_PUSH_B:
                    if (emit_ok) n_state = r_op.flush ? BS_TRIM : BS_IDLE;
                BS_TRIM:  n_state = BS_ALIGN;
                BS_ALIGN: if (r_sh == 3'd0) n_state = BS_FLUSH;
                BS_FLUSH: if (r_k == 3'd0) n_state = BS_END;
                BS_END:   if (out_free) n_state = BS_IDLE;
                default:  n_state = BS_IDLE;
            endcase
        end
    end

    // output register load
    always_comb begin
        out_load = 1'b0;
        o_chr    = chr;
        o_has    = 1'b1;
        o_last   = 1'b0;
        if (go && r_state == BS_END) begin
            out_load = out_free;
            o_chr    = r_hold_v ? r_hold_c : 8'h00;
            o_has    = r_hold_v;
            o_last   = 1'b1;
        end else if (want && emit_ok && (!r_op.flush || r_hold_v)) begin
            out_load = 1'b1;
            o_chr    = r_op.flush ? r_hold_c : chr;
        end
    end

    // datapath register next values
    always_comb begin
        n_op     = r_op;
        n_win    = r_win;
        n_seen   = r_seen;
        n_cnt    = r_cnt;
        n_k      = r_k;
        n_sh     = r_sh;
        n_xs     = r_xs;
        n_hold_v = r_hold_v;
        n_hold_c = r_hold_c;
        if (want && emit_ok && r_op.flush) begin
            n_hold_v = 1'b1;
            n_hold_c = chr;
        end
        if (r_xs) begin
            if (emit_ok) n_xs = 1'b0;
        end else begin
            unique case (r_state)
                BS_IDLE: if (i_op_valid) n_op = i_op;
                BS_PUSH_A, BS_PUSH_B: begin
                    if (emit_ok) begin
                        for (int j = 0; j < WIN - 1; j++) n_win[j] = r_win[j+1];
                        n_win[WIN-1] = push_l;
                        n_seen       = seen_p;
                        if (active) begin
                            n_cnt = r_cnt + CNT_W'(res.n);
                            n_xs  = res.n == 2'd2;
                        end
                    end
                end
                BS_TRIM: begin
                    // one trailing S is dropped before the last letters are coded
                    if (pend != 3'd0 && r_win[WIN-1] == "S") begin
                        for (int j = 1; j < WIN; j++) n_win[j] = r_win[j-1];
                        n_win[0] = CH_SP;
                        n_seen   = r_seen - 4'd1;
                        n_k      = pend - 3'd1;
                        n_sh     = 3'd6 - pend;
                    end else begin
                        n_k  = pend;
                        n_sh = 3'd5 - pend;
                    end
                end
                BS_ALIGN, BS_FLUSH: begin
                    if ((r_state == BS_ALIGN && r_sh != 3'd0) ||
                        (r_state == BS_FLUSH && r_k != 3'd0 && emit_ok)) begin
                        for (int j = 0; j < WIN - 1; j++) n_win[j] = r_win[j+1];
                        n_win[WIN-1] = CH_SP;
                        if (r_state == BS_ALIGN) begin
                            n_sh = r_sh - 3'd1;
                        end else begin
                            n_k = r_k - 3'd1;
                            if (active) begin
                                n_cnt = r_cnt + CNT_W'(res.n);
                                n_xs  = res.n == 2'd2;
                            end
                        end
                    end
                end
                BS_END: begin
                    if (out_free) begin
                        for (int j = 0; j < WIN; j++) n_win[j] = CH_SP;
                        n_seen   = '0;
                        n_cnt    = '0;
                        n_hold_v = 1'b0;
                    end
                end
                default: n_op = r_op;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_k      <= n_k;
        r_sh     <= n_sh;
        r_hold_c <= n_hold_c;
        if (out_load) begin
            r_oc <= o_chr;
            r_oh <= o_has;
            r_ol <= o_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BS_IDLE;
            for (int j = 0; j < WIN; j++) r_win[j] <= CH_SP;
            r_seen   <= '0;
            r_cnt    <= '0;
            r_xs     <= 1'b0;
            r_hold_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_win    <= n_win;
            r_seen   <= n_seen;
            r_cnt    <= n_cnt;
            r_xs     <= n_xs;
            r_hold_v <= n_hold_v;
            if (out_load) r_ov <= 1'b1;
            else if (o_out.ready) r_ov <= 1'b0;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.code_char    = r_oc;
    assign o_out.has_char     = r_oh;
    assign o_out.last_of_code = r_ol;
endmodule

// ----- rtl/mpe_checker.sv -----
// ----------------------------------------------------------------------------
// mpe_checker
// port-level checks on the encoder output channel
// ----------------------------------------------------------------------------
module mpe_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [7:0] i_code_char,
    input logic       i_has_char,
    input logic       i_last_of_code
);
    // stalled transaction holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_code_char) && $stable(i_has_char)
                                && $stable(i_last_of_code))
        else $error("output changed while stalled");

    // an empty marker always ends the code
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_has_char |-> i_last_of_code)
        else $error("empty marker without end of code");

    // code characters are capital letters or the th digit
    a_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_has_char |-> (i_code_char >= 8'h41 && i_code_char <= 8'h5a) ||
                                  (i_code_char == 8'h30))
        else $error("bad code character");

    // nothing comes out right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("output valid after reset");
endmodule

bind metaphone_phonetic_encoder mpe_checker u_mpe_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_out.valid),
    .i_ready        (o_out.ready),
    .i_code_char    (o_out.code_char),
    .i_has_char     (o_out.has_char),
    .i_last_of_code (o_out.last_of_code)
);

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// checks the metaphone encoder: words go in byte by byte, and every code
// character that comes out is compared with a predictor of the encoder, or
// with the code typed into a directed row
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mpe_pkg::*;

    localparam int unsigned LIMIT_PARAM = 50;
    localparam int          WDOG_LIMIT  = 5000;

    // a result transaction: code char, has_char, last_of_code
    typedef struct packed {
        logic [7:0] ch;
        logic       hc;
        logic       lc;
    } t_res;

    // a stimulus row; chk means the expected code is typed into the row
    typedef struct {
        string      word;
        logic [5:0] lim;
        logic       chk;
        string      code;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [5:0] i_cfg_wdata = '0;

    mpe_in_if  in_ch ();
    mpe_out_if out_ch ();

    metaphone_phonetic_encoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    // predictor state
    logic [5:0] pr_limit;
    logic [7:0] pr_win [WIN];
    int unsigned pr_seen, pr_count;
    t_phase     pr_phase;
    logic [7:0] pr_held;
    t_res       code_q [$];
    t_res       step_buf [$];

    // typed-in expected code for the current directed row
    bit    ovr_en = 1'b0;
    string ovr_code = "";

    int  n_fail = 0, n_items = 0, n_codes = 0, n_words = 0, idle_cnt = 0;
    logic no_idle = 1'b0;

    function automatic bit vow(logic [7:0] c);
        return c inside {"A", "E", "I", "O", "U"};
    endfunction

    function automatic bit frv(logic [7:0] c);
        return c inside {"E", "I", "Y"};
    endfunction

    function automatic void put_code(logic [7:0] c);
        t_res r;
        r.ch = c; r.hc = 1'b1; r.lc = 1'b0;
        step_buf.push_back(r);
        pr_count++;
    endfunction

    // context rules for one letter
    function automatic void encode_letter(int unsigned pos, logic [7:0] pv, logic [7:0] cu,
                                          logic [7:0] n1, logic [7:0] n2, logic [7:0] n3,
                                          int unsigned rem);
        int unsigned lim;
        bit va, fv, vb, sil;
        lim = (pr_limit < LIMIT_PARAM) ? pr_limit : LIMIT_PARAM;
        if (pr_count >= lim) return;
        if (pos == 0 && vow(cu)) begin
            put_code(cu);
            return;
        end
        vb = vow(pv); va = vow(n1); fv = frv(n1);
        if (cu == n1) return;
        case (cu)
            "B": if (!(rem == 0 && pv == "M")) put_code("B");
            "C": begin
                if (pos > 1 && pv == "S" && fv) ;
                else if (pos > 0 && n1 == "I" && n2 == "A") put_code("X");
                else if (fv) put_code("S");
                else if (pos > 1 && pv == "S" && n1 == "H") put_code("K");
                else if (n1 == "H") put_code((pos == 0 && !vow(n2)) ? "K" : "X");
                else put_code(pv == "C" ? "C" : "K");
            end
            "D": put_code((n1 == "G" && frv(n2)) ? "J" : "T");
            "G": begin
                sil = 0;
                if (rem >= 2 && n1 == "H" && !vow(n2)) sil = 1;
                if (rem == 3 && n1 == "N" && n2 == "E" && n3 == "D") sil = 1;
                else if (rem == 1 && n1 == "N") sil = 1;
                if (pv == "D" && fv) sil = 1;
                if (!sil) put_code((fv && pv != "G") ? "J" : "K");
            end
            "H": if (!(pv inside {"C", "S", "P", "T", "G"}) && !(vb && !va)) put_code("H");
            "F", "J", "L", "M", "N", "R": put_code(cu);
            "K": if (pv != "C") put_code("K");
            "P": put_code(n1 == "H" ? "F" : "P");
            "Q": put_code("K");
            "S": begin
                if (pos > 1 && n1 == "I" && (n2 == "O" || n2 == "A")) put_code("X");
                else put_code(n1 == "H" ? "X" : "S");
            end
            "T": begin
                if (pos > 1 && n1 == "I" && (n2 == "O" || n2 == "A")) put_code("X");
                else if (n1 == "H") put_code((pos > 0 || vow(n2)) ? CH_TH : "T");
                else if (!(rem >= 3 && n1 == "C" && n2 == "H")) put_code("T");
            end
            "V": put_code("F");
            "W", "Y": if (rem > 0 && va) put_code(cu);
            "X": begin
                put_code("K");
                put_code("S");
            end
            "Z": put_code("S");
            default: ;
        endcase
    endfunction

    function automatic void push_win(logic [7:0] c);
        int unsigned ix;
        for (int j = 0; j < WIN - 1; j++) pr_win[j] = pr_win[j + 1];
        pr_win[WIN - 1] = c;
        if (pr_seen < SEEN_SAT) pr_seen++;
        if (pr_seen >= 6) begin
            ix = pr_seen - 6;
            encode_letter(ix > 2 ? 2 : ix, pr_win[0], pr_win[1], pr_win[2], pr_win[3],
                          pr_win[4], 4);
        end
    endfunction

    function automatic void clear_word();
        for (int j = 0; j < WIN; j++) pr_win[j] = CH_SP;
        pr_seen = 0; pr_count = 0; pr_phase = PH_NONE; pr_held = CH_SP;
    endfunction

    // one input transaction; expected code chars are appended to code_q
    function automatic void predict_byte(logic [7:0] b, logic last);
        logic [7:0] c;
        bit let_b, hit;
        int unsigned pend, rem, ix;
        t_res r;
        c = b; let_b = 0;
        step_buf.delete();
        if (c >= "a" && c <= "z") begin
            c = c - 8'd32; let_b = 1;
        end else if (c >= "A" && c <= "Z") let_b = 1;
        if (let_b) begin
            if (pr_phase == PH_NONE) begin
                pr_held = c; pr_phase = PH_HELD;
            end else if (pr_phase == PH_HELD) begin
                // silent-first-letter prefixes AE GN KN PN WR
                hit = (pr_held == "A" && c == "E") || (pr_held == "G" && c == "N") ||
                      (pr_held == "K" && c == "N") || (pr_held == "P" && c == "N") ||
                      (pr_held == "W" && c == "R");
                if (hit) push_win(c);
                else if (pr_held == "X") begin
                    push_win("S"); push_win(c);
                end else if (pr_held == "W" && c == "H") push_win("W");
                else begin
                    push_win(pr_held); push_win(c);
                end
                pr_phase = PH_OPEN;
            end else push_win(c);
        end
        if (last) begin
            if (pr_phase == PH_HELD) push_win(pr_held == "X" ? "S" : pr_held);
            pend = pr_seen < 5 ? pr_seen : 5;
            if (pend > 0 && pr_win[WIN - 1] == "S") begin
                for (int j = WIN - 1; j > 0; j--) pr_win[j] = pr_win[j - 1];
                pr_win[0] = CH_SP; pend--; pr_seen--;
            end
            for (int j = WIN - pend; j < WIN; j++) begin
                rem = WIN - 1 - j;
                ix = pr_seen - 1 - rem;
                encode_letter(ix > 2 ? 2 : ix, pr_win[j - 1], pr_win[j],
                              rem >= 1 ? pr_win[j + 1] : CH_SP,
                              rem >= 2 ? pr_win[j + 2] : CH_SP,
                              rem >= 3 ? pr_win[j + 3] : CH_SP, rem);
            end
            if (ovr_en) begin
                // directed row: the whole code is taken from the table
                step_buf.delete();
                for (int k = 0; k < ovr_code.len(); k++) begin
                    r.ch = ovr_code[k]; r.hc = 1'b1; r.lc = 1'b0;
                    step_buf.push_back(r);
                end
            end
            if (step_buf.size() > 0) step_buf[$].lc = 1'b1;
            else begin
                r.ch = 8'd0; r.hc = 1'b0; r.lc = 1'b1;
                step_buf.push_back(r);
            end
            clear_word();
        end
        foreach (step_buf[k]) code_q.push_back(step_buf[k]);
    endfunction

    // result side: random stall, compare at the rising edge
    initial out_ch.ready = 1'b0;
    always @(negedge i_clk) out_ch.ready <= no_idle || ($urandom_range(99) >= 34);

    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && (in_ch.valid && in_ch.ready || out_ch.valid && out_ch.ready))
            idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            n_codes <= n_codes + 1;
            if (code_q.size() == 0) begin
                $error("unexpected result transaction code_char=%h", out_ch.code_char);
                n_fail <= n_fail + 1;
            end else begin
                e = code_q.pop_front();
                if (e.hc !== out_ch.has_char) begin
                    $error("has_char exp %b got %b", e.hc, out_ch.has_char);
                    n_fail <= n_fail + 1;
                end
                if (e.ch !== out_ch.code_char) begin
                    $error("code_char exp %h got %h", e.ch, out_ch.code_char);
                    n_fail <= n_fail + 1;
                end
                if (e.lc !== out_ch.last_of_code) begin
                    $error("last_of_code exp %b got %b", e.lc, out_ch.last_of_code);
                    n_fail <= n_fail + 1;
                end
            end
        end
    end

    // watchdog on cycles with no transaction at all
    always @(posedge i_clk) begin
        if (idle_cnt >= WDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", WDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // drive one byte; waits for the handshake, idles at random before it
    task automatic send_byte(logic [7:0] b, logic last);
        while (!no_idle && $urandom_range(99) < 34) @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.char_byte <= b;
        in_ch.last_of_word <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_byte(b, last);
        n_items++;
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic send_word(string w);
        for (int i = 0; i < w.len(); i++) send_byte(w[i], i == w.len() - 1);
        n_words++;
    endtask

    // drain, then let the sequencer settle before a register write
    task automatic set_limit(logic [5:0] v);
        while (code_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        pr_limit = v;
    endtask

    function automatic logic [7:0] rand_letter();
        logic [7:0] c;
        c = "A" + $urandom_range(25);
        return $urandom_range(1) ? c : c + 8'd32;
    endfunction

    t_row rows [$];
    string pieces [$] = '{"TH", "CH", "SH", "GH", "PH", "CIA", "SIO", "TIA", "DGE",
                          "GNED", "SCH", "TCH", "WH", "MB", "CK", "X", "Y", "A", "E"};

    initial begin
        string w;
        int nlen;
        logic [5:0] lims [6] = '{6'd50, 6'd1, 6'd0, 6'd63, 6'd4, 6'd12};
        in_ch.valid = 1'b0;
        in_ch.char_byte = '0;
        in_ch.last_of_word = 1'b0;
        pr_limit = CFG_RESET;
        clear_word();

        // expected codes typed in where obvious; the rest uses the predictor
        rows.push_back('{"X", 6'd50, 1, ""});
        rows.push_back('{"12!", 6'd50, 1, ""});
        rows.push_back('{"thumb", 6'd50, 0, ""});
        rows.push_back('{"KNIGHT", 6'd50, 0, ""});
        rows.push_back('{"aerial", 6'd50, 0, ""});
        rows.push_back('{"gnome", 6'd50, 0, ""});
        rows.push_back('{"pneu", 6'd50, 0, ""});
        rows.push_back('{"WRITE", 6'd50, 0, ""});
        rows.push_back('{"xerox", 6'd50, 0, ""});
        rows.push_back('{"WHITE", 6'd50, 0, ""});
        rows.push_back('{"cats", 6'd50, 0, ""});
        rows.push_back('{"bell", 6'd50, 0, ""});
        rows.push_back('{"schtick", 6'd50, 0, ""});
        rows.push_back('{"nation", 6'd50, 0, ""});
        rows.push_back('{"signed", 6'd50, 0, ""});
        rows.push_back('{"judge", 6'd50, 0, ""});
        rows.push_back('{"MMM", 6'd1, 1, "M"});
        rows.push_back('{"taxi", 6'd1, 0, ""});
        rows.push_back('{"LAMB", 6'd0, 1, ""});
        rows.push_back('{"philosophy", 6'd63, 0, ""});
        rows.push_back('{"quiz vex", 6'd63, 0, ""});

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[r]) begin
            if (rows[r].lim != pr_limit) set_limit(rows[r].lim);
            ovr_en   = rows[r].chk;
            ovr_code = rows[r].code;
            send_word(rows[r].word);
            ovr_en   = 1'b0;
        end
        // non-letter and high bytes around one letter, with a non-letter final byte
        send_byte(8'hFF, 1'b0);
        send_byte("b", 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b1);

        for (int ph = 0; ph < 6; ph++) begin
            set_limit(lims[ph]);
            no_idle = (ph == 3);
            while (n_items < 15 * (ph + 1) + 110) begin
                w = "";
                if ($urandom_range(9) == 0) begin
                    nlen = $urandom_range(1, 5);
                    for (int k = 0; k < nlen; k++) w = {w, string'(8'($urandom))};
                end else begin
                    nlen = $urandom_range(1, 4);
                    for (int k = 0; k < nlen; k++) begin
                        if ($urandom_range(2) == 0) w = {w, pieces[$urandom_range(18)]};
                        else w = {w, string'(rand_letter())};
                    end
                    if ($urandom_range(3) == 0) w = {w, "s"};
                end
                if (w.len() == 0) w = "a";
                send_word(w);
            end
        end
        no_idle = 1'b0;

        while (code_q.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
        $display("covered %0d words, %0d bytes, %0d code transactions, limits 0..63",
                 n_words, n_items, n_codes);
        if (n_fail == 0 && code_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
